/* rtl/mpnt_pkg.sv */
package mpnt_pkg;

  // Fixed field widths of the stream words.
  localparam int EXP_W   = 6;
  localparam int VALUE_W = 63;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the exponent and set up the first divisor
    logic div_start;  // begin a remainder pass for the current divisor
    logic div_step;   // one bit of the restoring remainder
    logic advance;    // move to the next divisor
    logic finish;     // write the result word into the output register
    logic prime;      // verdict that goes with finish
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_ok;   // exponent lies in 2..MAX_EXPONENT
    logic sq_above;   // divisor squared exceeds the Mersenne number
    logic div_last;   // the current remainder step is the final one
    logic rem_zero;   // the divisor divides the Mersenne number exactly
    logic out_busy;   // output register holds a word not yet taken
  } status_t;

endpackage

/* rtl/mpnt_ctrl.sv */
module mpnt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mpnt_pkg::status_t status,
  output mpnt_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DIV,
    EVAL,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   verdict;
  logic   verdict_next;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    verdict_next = verdict;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (!status.range_ok) begin
          verdict_next = 1'b0;
          state_next   = FINISH;
        end else if (status.sq_above) begin
          verdict_next = 1'b1;
          state_next   = FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = DIV;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = EVAL;
        end
      end
      EVAL: begin
        if (status.rem_zero) begin
          verdict_next = 1'b0;
          state_next   = FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = CHECK;
        end
      end
      FINISH: begin
        cmd.prime = verdict;
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b1;
      verdict  <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == IDLE);
      verdict  <= verdict_next;
    end
  end

endmodule

/* rtl/mpnt_dp.sv */
module mpnt_dp #(
  parameter int MAX_EXPONENT = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mpnt_pkg::EXP_W-1:0]       exponent,
  input  mpnt_pkg::cmd_t                   cmd,
  output mpnt_pkg::status_t                status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [mpnt_pkg::EXP_W-1:0]       out_exponent,
  output logic                             out_perfect,
  output logic [mpnt_pkg::VALUE_W-1:0]     out_value
);

  localparam int EW    = mpnt_pkg::EXP_W;
  localparam int VW    = mpnt_pkg::VALUE_W;
  localparam int M_W   = MAX_EXPONENT;
  localparam int D_W   = MAX_EXPONENT / 2 + 1;
  localparam int SQ_W  = 2 * D_W;
  localparam int CNT_W = (M_W > 1) ? $clog2(M_W) : 1;

  logic [EW-1:0]    p;
  logic [M_W-1:0]   m;
  logic [D_W-1:0]   d;
  logic [SQ_W-1:0]  sq;
  logic [D_W-1:0]   rem;
  logic [M_W-1:0]   shreg;
  logic [CNT_W-1:0] cnt;

  logic [M_W-1:0]   m_init;
  logic [D_W:0]     shifted;
  logic             fits;
  logic [VW-1:0]    value_calc;

  // All ones in the low p bits: 2^p - 1, also right when p equals the width.
  assign m_init  = ~({M_W{1'b1}} << exponent);
  assign shifted = {rem, shreg[M_W-1]};
  assign fits    = (shifted >= {1'b0, d});
  assign value_calc = {{(VW-M_W){1'b0}}, m} << (p - EW'(1));

  assign status.range_ok = (p >= EW'(2)) && (p <= EW'(MAX_EXPONENT));
  assign status.sq_above = (sq > SQ_W'(m));
  assign status.div_last = (cnt == '0);
  assign status.rem_zero = (rem == '0);
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p  <= exponent;
      m  <= m_init;
      d  <= D_W'(2);
      sq <= SQ_W'(4);
    end
    if (cmd.div_start) begin
      rem   <= '0;
      shreg <= m;
      cnt   <= CNT_W'(M_W - 1);
    end
    if (cmd.div_step) begin
      rem   <= fits ? D_W'(shifted - {1'b0, d}) : D_W'(shifted);
      shreg <= shreg << 1;
      cnt   <= cnt - CNT_W'(1);
    end
    if (cmd.advance) begin
      d  <= d + D_W'(1);
      sq <= sq + SQ_W'({d, 1'b1});
    end
    if (cmd.finish) begin
      out_exponent <= p;
      out_perfect  <= cmd.prime;
      out_value    <= cmd.prime ? value_calc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/mersenne_perfect_number_test_unit.sv */
// An exponent outside 2..MAX_EXPONENT is answered straight from the range check;
// otherwise divisors from 2 up are tried until one divides 2^p - 1 or squares above it.
// Throughput: one word at a time; the bit-serial remainder loop sets the pace.
// Reset (rst, synchronous, active high) empties the output register and
// returns the controller to idle; no memory needs clearing.
module mersenne_perfect_number_test_unit #(
  parameter int MAX_EXPONENT = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata: [5:0] exponent, [7:6] zero
  input  logic [mpnt_pkg::IN_TDATA_W-1:0]        s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata: [5:0] exponent_echo, [68:6] perfect_value, [71:69] zero
  output logic [mpnt_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // m_tuser: [0] is_perfect
  output logic                                   m_tuser
);

  localparam int EW  = mpnt_pkg::EXP_W;
  localparam int VW  = mpnt_pkg::VALUE_W;
  localparam int PAD = mpnt_pkg::OUT_TDATA_W - EW - VW;

  // The controller sequences divisors and remainder passes; the datapath
  // holds the Mersenne number, the divisor with its running square, the
  // bit-serial remainder and the output register that parts the two sides.
  mpnt_pkg::cmd_t    cmd;
  mpnt_pkg::status_t status;

  logic [EW-1:0] out_exponent;
  logic [VW-1:0] out_value;

  mpnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mpnt_dp #(
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .exponent     (s_tdata[EW-1:0]),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_exponent (out_exponent),
    .out_perfect  (m_tuser),
    .out_value    (out_value)
  );

  // The result word: exponent in the low bits, then the perfect number.
  assign m_tdata = {{PAD{1'b0}}, out_value, out_exponent};

endmodule

/* sim/mersenne_perfect_number_test_unit_tb.sv */
`timescale 1ns / 100ps

module mersenne_perfect_number_test_unit_tb;

  // The unit is built with the default exponent ceiling; the predictor uses the same one.
  localparam int MAX_EXP = 32;
  localparam int MIN_EXP = 2;
  // The one slow exponent: 2^31-1 is prime, so trial division runs to its square root.
  localparam logic [mpnt_pkg::EXP_W-1:0] SLOW_EXP = 6'd31;
  localparam int PAUSE_MAX = 18;
  localparam int RANDOM_WORDS = 75;
  // Cycles with no word moving on either side before the run is declared hung.
  // The limit lies well above the time the unit spends on the p = 31 word.
  localparam int unsigned IDLE_LIMIT = 5_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [mpnt_pkg::EXP_W-1:0]   exponent;
    logic                         prime;
    logic [mpnt_pkg::VALUE_W-1:0] value;
  } perfect_result_t;

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [mpnt_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [mpnt_pkg::OUT_TDATA_W-1:0]   m_tdata;
  logic                               m_tuser;

  logic [mpnt_pkg::EXP_W-1:0] exponent_queue[$];
  perfect_result_t            expected_results[$];

  int unsigned sent_words     = 0;
  int unsigned received_words = 0;
  int unsigned send_pause     = 0;
  int unsigned recv_pause     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned mismatch_count = 0;

  mersenne_perfect_number_test_unit #(
    .MAX_EXPONENT(MAX_EXP)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclid-Euler check of one exponent: m = 2^p - 1 is tried against every divisor
  // whose square does not exceed it. A prime m yields the perfect number m * 2^(p-1).
  function automatic perfect_result_t predict_perfect(logic [mpnt_pkg::EXP_W-1:0] p);
    perfect_result_t r;
    logic [63:0]     m;
    logic [63:0]     d;
    logic            composite;
    r.exponent = p;
    r.prime    = 1'b0;
    r.value    = '0;
    if (p >= MIN_EXP && p <= MAX_EXP) begin
      m = (64'd1 << p) - 64'd1;
      composite = 1'b0;
      for (d = 64'd2; d * d <= m && !composite; d++) begin
        if (m % d == 64'd0) begin
          composite = 1'b1;
        end
      end
      if (!composite) begin
        r.prime = 1'b1;
        r.value = mpnt_pkg::VALUE_W'(m << (p - 1));
      end
    end
    return r;
  endfunction

  // The first ten words of every forty run back to back; otherwise the pause is random.
  function automatic int unsigned draw_pause(int unsigned word_index);
    if ((word_index % 40) < 10) begin
      return 0;
    end
    return $urandom_range(0, PAUSE_MAX);
  endfunction

  task automatic note_mismatch(string what, perfect_result_t want, perfect_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t: %s: expected exp=%0d prime=%0b value=%0d, got exp=%0d prime=%0b value=%0d",
               $realtime, what, want.exponent, want.prime, want.value,
               got.exponent, got.prime, got.value);
    end
  endtask

  // Sending side. The expectation is worked out when the unit takes the word, then the
  // next exponent is offered once the drawn pause has run out.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      send_pause <= draw_pause(0);
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_perfect(s_tdata[mpnt_pkg::EXP_W-1:0]));
        sent_words++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_pause != 0) begin
          s_tvalid   <= 1'b0;
          send_pause <= send_pause - 1;
        end else if (exponent_queue.size() != 0) begin
          s_tvalid   <= 1'b1;
          s_tdata    <= {{(mpnt_pkg::IN_TDATA_W - mpnt_pkg::EXP_W){1'b0}},
                         exponent_queue.pop_front()};
          send_pause <= draw_pause(sent_words + 1);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiving side. Each result word is checked against the oldest expectation, then
  // ready is held low for a freshly drawn number of cycles.
  always @(posedge clk) begin : result_monitor
    perfect_result_t got;
    perfect_result_t want;
    int unsigned     n;
    if (rst) begin
      m_tready   <= 1'b0;
      recv_pause <= 0;
    end else if (m_tvalid && m_tready) begin
      got.exponent = m_tdata[mpnt_pkg::EXP_W-1:0];
      got.value    = m_tdata[mpnt_pkg::EXP_W +: mpnt_pkg::VALUE_W];
      got.prime    = m_tuser;
      if (expected_results.size() == 0) begin
        want = '0;
        note_mismatch("result word with nothing outstanding", want, got);
      end else begin
        want = expected_results.pop_front();
        if (got.exponent !== want.exponent || got.prime !== want.prime ||
            got.value !== want.value) begin
          note_mismatch("result word differs", want, got);
        end
      end
      received_words++;
      n = draw_pause(received_words);
      m_tready   <= (n == 0);
      recv_pause <= n;
    end else if (!m_tready) begin
      if (recv_pause <= 1) begin
        m_tready <= 1'b1;
      end
      if (recv_pause != 0) begin
        recv_pause <= recv_pause - 1;
      end
    end
  end

  // Watchdog: the run is abandoned if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [mpnt_pkg::EXP_W-1:0] p;
    // Directed words: exponents zero and one, every Mersenne prime in range including
    // the slow p = 31, composite exponents, the ceiling and a selection beyond it.
    exponent_queue = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
                       6'd11, 6'd13, 6'd16, 6'd17, 6'd19, 6'd23, 6'd25, 6'd29,
                       SLOW_EXP, 6'd32, 6'd33, 6'd42, 6'd48, 6'd62, 6'd63};
    // Random words: three quarters inside the tested range so that most reach the
    // divisor loop, the rest anywhere in the field. The slow exponent is not repeated.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      do begin
        if ($urandom_range(0, 3) != 0) begin
          p = mpnt_pkg::EXP_W'($urandom_range(MIN_EXP, MAX_EXP));
        end else begin
          p = mpnt_pkg::EXP_W'($urandom_range(0, (1 << mpnt_pkg::EXP_W) - 1));
        end
      end while (p == SLOW_EXP);
      exponent_queue.push_back(p);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (exponent_queue.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
